### src/hps_pkg.sv
// hps_pkg: shared types and constants for the homing positioner
// sequencer mode codes, configuration register indexes, state record
// no dependencies
package hps_pkg;

  localparam int unsigned TravelW  = 16;
  localparam int unsigned TimeoutW = 16;
  localparam int unsigned DebW     = 8;
  localparam int unsigned PctW     = 7;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  // percent times travel, up to 100 * 65535
  localparam int unsigned ProdW    = PctW + TravelW;

  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_HOMING = 2'd1;
  localparam logic [1:0] MODE_LEFT   = 2'd2;
  localparam logic [1:0] MODE_FAULT  = 2'd3;

  localparam logic [CfgIdxW-1:0] CFG_MAX_TRAVEL   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HOME_TIMEOUT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE     = 2'd2;

  localparam logic [TravelW-1:0]  RST_MAX_TRAVEL   = 16'd20000;
  localparam logic [TimeoutW-1:0] RST_HOME_TIMEOUT = 16'd50000;
  localparam logic [DebW-1:0]     RST_DEBOUNCE     = 8'd200;

  localparam logic [PctW-1:0]  PCT_FULL  = 7'd100;
  localparam logic [ProdW-1:0] PCT_SCALE = 23'd100;
  localparam logic [DebW-1:0]  HOLD_MAX  = 8'd255;

  typedef struct packed {
    logic [1:0]          mode;
    logic [TimeoutW-1:0] home_cnt;
    logic [DebW-1:0]     hold_cnt;
    // remaining left travel kept scaled by 100: ticks left = move_rem / 100
    logic [ProdW-1:0]    move_rem;
  } hps_state_t;

  typedef struct packed {
    logic [TravelW-1:0]  max_travel;
    logic [TimeoutW-1:0] home_timeout;
    logic [DebW-1:0]     debounce;
  } hps_cfg_t;

endpackage

### src/hps_if.sv
// hps_in_if / hps_out_if: valid-ready channels of the homing positioner
// depends on hps_pkg for field widths
interface hps_in_if;
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic [hps_pkg::PctW-1:0] position_percent;
  logic                     sensor_level;

  modport source (output valid, output req_type, output position_percent,
                  output sensor_level, input ready);
  modport sink (input valid, input req_type, input position_percent,
                input sensor_level, output ready);
endinterface

interface hps_out_if;
  logic       valid;
  logic       ready;
  logic       drive_right;
  logic       drive_left;
  logic [1:0] mode;

  modport source (output valid, output drive_right, output drive_left,
                  output mode, input ready);
  modport sink (input valid, input drive_right, input drive_left,
                input mode, output ready);
endinterface

### src/hps_step.sv
// hps_step: next-state logic of the sequencer for one request
// depends on hps_pkg
module hps_step (
  input  hps_pkg::hps_state_t       cur,
  input  hps_pkg::hps_cfg_t         cfg,
  input  logic                      req_type,
  input  logic [hps_pkg::PctW-1:0]  position_percent,
  input  logic                      sensor_level,
  output hps_pkg::hps_state_t       nxt
);

  logic [hps_pkg::PctW-1:0]  pct_clamped;
  logic [hps_pkg::ProdW-1:0] prod;
  logic [hps_pkg::ProdW-1:0] rem_dec;

  assign pct_clamped = (position_percent > hps_pkg::PCT_FULL) ? hps_pkg::PCT_FULL
                                                              : position_percent;
  assign prod    = hps_pkg::ProdW'(pct_clamped) * hps_pkg::ProdW'(cfg.max_travel);
  assign rem_dec = cur.move_rem - hps_pkg::PCT_SCALE;

  always_comb begin
    nxt = cur;
    if (cur.mode != hps_pkg::MODE_FAULT) begin
      if (req_type) begin
        nxt.move_rem = prod;
        nxt.hold_cnt = '0;
        nxt.mode     = hps_pkg::MODE_HOMING;
      end else if (cur.mode == hps_pkg::MODE_HOMING) begin
        if (cur.home_cnt >= cfg.home_timeout) begin
          nxt.mode = hps_pkg::MODE_FAULT;
        end else if (sensor_level && (cur.hold_cnt >= cfg.debounce)) begin
          nxt.home_cnt = '0;
          nxt.hold_cnt = '0;
          nxt.mode     = (cur.move_rem >= hps_pkg::PCT_SCALE) ? hps_pkg::MODE_LEFT
                                                              : hps_pkg::MODE_IDLE;
        end else begin
          nxt.home_cnt = cur.home_cnt + 1'b1;
          if (!sensor_level) begin
            nxt.hold_cnt = '0;
          end else if (cur.hold_cnt != hps_pkg::HOLD_MAX) begin
            nxt.hold_cnt = cur.hold_cnt + 1'b1;
          end
        end
      end else if (cur.mode == hps_pkg::MODE_LEFT) begin
        // in left mode at least one whole tick remains
        nxt.move_rem = rem_dec;
        if (rem_dec < hps_pkg::PCT_SCALE) begin
          nxt.mode = hps_pkg::MODE_IDLE;
        end
      end
    end
  end

endmodule

### src/homing_positioner_with_debounce_unit.sv
// homing_positioner_with_debounce_unit: top level of the homing positioner
// depends on hps_pkg, hps_in_if / hps_out_if and hps_step
//
// Each request (a tick with a home sensor sample, or a position command) gives
// exactly one result showing the drive outputs and mode after that request.
// Throughput is one request per clock: the state update is a single pass of
// short logic (one 7x16 multiply on commands, 16-bit and 8-bit counters and
// compares) and the result is registered in the output register on acceptance.
// in_ch.ready stays high while the output register is empty or being taken,
// so requests flow back to back whenever the result side keeps taking them;
// a stalled result holds off the next request until it is taken.
// The left-travel target is held scaled by 100 and counted down by 100 per
// tick, so no divider is needed. A timeout while homing is a sticky fault
// that only rst_n clears. Configuration writes take effect on the next
// request; a target already computed is kept.
module homing_positioner_with_debounce_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  hps_in_if.sink                        in_ch,
  hps_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [hps_pkg::CfgIdxW-1:0]   cfg_idx,
  input  logic [hps_pkg::CfgDataW-1:0]  cfg_data
);

  hps_pkg::hps_cfg_t   cfg_r;
  hps_pkg::hps_state_t st_r;
  hps_pkg::hps_state_t st_nxt;
  logic                out_valid_r;
  logic                drive_right_r;
  logic                drive_left_r;
  logic [1:0]          mode_r;
  logic                in_acc;

  // request accepted when the output register is free or draining
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_travel   <= hps_pkg::RST_MAX_TRAVEL;
      cfg_r.home_timeout <= hps_pkg::RST_HOME_TIMEOUT;
      cfg_r.debounce     <= hps_pkg::RST_DEBOUNCE;
    end else if (cfg_we) begin
      case (cfg_idx)
        hps_pkg::CFG_MAX_TRAVEL:   cfg_r.max_travel   <= cfg_data;
        hps_pkg::CFG_HOME_TIMEOUT: cfg_r.home_timeout <= cfg_data;
        hps_pkg::CFG_DEBOUNCE:     cfg_r.debounce     <= cfg_data[hps_pkg::DebW-1:0];
        default: ;
      endcase
    end
  end

  // sequencer next state for the request on the input channel
  hps_step u_step (
    .cur              (st_r),
    .cfg              (cfg_r),
    .req_type         (in_ch.req_type),
    .position_percent (in_ch.position_percent),
    .sensor_level     (in_ch.sensor_level),
    .nxt              (st_nxt)
  );

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode     <= hps_pkg::MODE_IDLE;
      st_r.home_cnt <= '0;
      st_r.hold_cnt <= '0;
      st_r.move_rem <= '0;
    end else if (in_acc) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      drive_right_r <= (st_nxt.mode == hps_pkg::MODE_HOMING);
      drive_left_r  <= (st_nxt.mode == hps_pkg::MODE_LEFT);
      mode_r        <= st_nxt.mode;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.drive_right = drive_right_r;
  assign out_ch.drive_left  = drive_left_r;
  assign out_ch.mode        = mode_r;

endmodule

### tb/sv/homing_sequence_monitor.sv
// homing_sequence_monitor: watches the request, result and register ports of the
// homing positioner, predicts every result and compares it field by field
// depends on hps_pkg and the hps_in_if / hps_out_if interfaces
module homing_sequence_monitor
  import hps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  hps_in_if                     in_mon,
  hps_out_if                    out_mon,
  input  logic                  cfg_we,
  input  logic [CfgIdxW-1:0]    cfg_idx,
  input  logic [CfgDataW-1:0]   cfg_data,
  output int                    fail_count,
  output int                    outstanding,
  output int                    results_checked,
  output logic [1:0]            seq_mode,
  output logic [TimeoutW-1:0]   seq_home_ticks
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]          mode;
    logic [TimeoutW-1:0] homing_ticks;
    logic [DebW-1:0]     hold;
    logic [TravelW-1:0]  travel_left;
  } seq_state_t;

  typedef struct packed {
    logic       right;
    logic       left;
    logic [1:0] mode;
  } drive_result_t;

  seq_state_t    seq;
  hps_cfg_t      regs;
  drive_result_t expected_drive_q[$];

  // one request applied to the sequencer state
  function automatic seq_state_t advance_sequencer(seq_state_t s, hps_cfg_t r, logic is_cmd,
                                                   logic [PctW-1:0] pct, logic active);
    seq_state_t      n;
    logic [PctW-1:0] p;
    logic [ProdW-1:0] scaled;
    n = s;
    if (s.mode != MODE_FAULT) begin
      if (is_cmd) begin
        p = (pct > PCT_FULL) ? PCT_FULL : pct;
        scaled = ProdW'(p) * ProdW'(r.max_travel);
        n.travel_left = TravelW'(scaled / PCT_SCALE);
        n.hold = '0;
        n.mode = MODE_HOMING;
      end else if (s.mode == MODE_HOMING) begin
        if (s.homing_ticks >= r.home_timeout) begin
          n.mode = MODE_FAULT;
        end else if (active && s.hold >= r.debounce) begin
          n.homing_ticks = '0;
          n.hold = '0;
          n.mode = (s.travel_left != '0) ? MODE_LEFT : MODE_IDLE;
        end else begin
          n.homing_ticks = s.homing_ticks + 1'b1;
          if (!active) n.hold = '0;
          else if (s.hold != HOLD_MAX) n.hold = s.hold + 1'b1;
        end
      end else if (s.mode == MODE_LEFT) begin
        if (s.travel_left != '0) n.travel_left = s.travel_left - 1'b1;
        if (n.travel_left == '0) n.mode = MODE_IDLE;
      end
    end
    return n;
  endfunction

  always @(posedge clk) begin
    drive_result_t want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      seq = '0;
      seq.mode = MODE_IDLE;
      regs.max_travel = RST_MAX_TRAVEL;
      regs.home_timeout = RST_HOME_TIMEOUT;
      regs.debounce = RST_DEBOUNCE;
      expected_drive_q.delete();
    end else begin
      // results first: a request accepted now cannot have its result out yet
      if (out_mon.valid && out_mon.ready) begin
        if (expected_drive_q.size() == 0) begin
          $error("result with no request waiting: mode %0d", out_mon.mode);
          errs++;
        end else begin
          want = expected_drive_q.pop_front();
          if (out_mon.drive_right !== want.right) begin
            $error("drive_right: expected %0d, actual %0d", want.right, out_mon.drive_right);
            errs++;
          end
          if (out_mon.drive_left !== want.left) begin
            $error("drive_left: expected %0d, actual %0d", want.left, out_mon.drive_left);
            errs++;
          end
          if (out_mon.mode !== want.mode) begin
            $error("mode: expected %0d, actual %0d", want.mode, out_mon.mode);
            errs++;
          end
          results_checked <= results_checked + 1;
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        seq = advance_sequencer(seq, regs, in_mon.req_type, in_mon.position_percent,
                                in_mon.sensor_level);
        want.right = (seq.mode == MODE_HOMING);
        want.left  = (seq.mode == MODE_LEFT);
        want.mode  = seq.mode;
        expected_drive_q.push_back(want);
      end
      // register writes count from the next request on
      if (cfg_we) begin
        case (cfg_idx)
          CFG_MAX_TRAVEL:   regs.max_travel = cfg_data[TravelW-1:0];
          CFG_HOME_TIMEOUT: regs.home_timeout = cfg_data[TimeoutW-1:0];
          CFG_DEBOUNCE:     regs.debounce = cfg_data[DebW-1:0];
          default: ;
        endcase
      end
    end
    fail_count <= fail_count + errs;
    outstanding <= expected_drive_q.size();
    seq_mode <= seq.mode;
    seq_home_ticks <= seq.homing_ticks;
  end

endmodule

### tb/sv/homing_positioner_with_debounce_unit_test.sv
// homing_positioner_with_debounce_unit_test: stimulus and verdict for the homing positioner
// drives directed and random requests under changing register settings and idling
// depends on hps_pkg, hps_in_if / hps_out_if, the block and homing_sequence_monitor
module homing_positioner_with_debounce_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import hps_pkg::*;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  hps_in_if  in_ch();
  hps_out_if out_ch();

  // idling knobs, percent per cycle
  int gap_pct;
  int stall_pct;

  int n_requests;
  int n_commands;

  int                  fail_count;
  int                  outstanding;
  int                  results_checked;
  logic [1:0]          seq_mode;
  logic [TimeoutW-1:0] seq_home_ticks;

  homing_positioner_with_debounce_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  homing_sequence_monitor seq_mon (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .cfg_we          (cfg_we),
    .cfg_idx         (cfg_idx),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .results_checked (results_checked),
    .seq_mode        (seq_mode),
    .seq_home_ticks  (seq_home_ticks)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // result side back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // one request: optional idle cycles, then hold it until the block takes it
  task automatic send_request(input logic is_cmd, input logic [PctW-1:0] pct,
                              input logic sensor);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.req_type <= is_cmd;
    in_ch.position_percent <= pct;
    in_ch.sensor_level <= sensor;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n_requests++;
    if (is_cmd) n_commands++;
  endtask

  // stop sending and wait until every request has its result back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    // a little margin after the last result is checked
    repeat (3) @(posedge clk);
  endtask

  // all three registers back to back, only while nothing is in flight
  task automatic program_regs(input logic [TravelW-1:0] travel,
                              input logic [TimeoutW-1:0] timeout,
                              input logic [DebW-1:0] deb);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_MAX_TRAVEL;
    cfg_data <= travel;
    @(posedge clk);
    cfg_idx <= CFG_HOME_TIMEOUT;
    cfg_data <= timeout;
    @(posedge clk);
    cfg_idx <= CFG_DEBOUNCE;
    cfg_data <= {{(CfgDataW-DebW){1'b0}}, deb};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly in range, some exact ends, a good share above full scale
  function automatic logic [PctW-1:0] pick_percent();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return PctW'($urandom_range(0, 100));
    if (r < 68) return '0;
    if (r < 76) return PCT_FULL;
    return PctW'($urandom_range(101, 127));
  endfunction

  // well-formed run: command, sensor bounce, a clean hold long enough to home,
  // then a stretch of left travel that may or may not finish
  task automatic homing_run(input int unsigned deb);
    int unsigned bounce;
    int unsigned hold_run;
    int unsigned coast;
    bounce = $urandom_range(0, 6);
    hold_run = deb + 1 + $urandom_range(0, 2);
    coast = $urandom_range(0, 40);
    send_request(1'b1, pick_percent(), 1'($urandom));
    repeat (bounce) send_request(1'b0, PctW'($urandom), 1'($urandom));
    // retarget while homing now and then
    if ($urandom_range(0, 9) == 0) send_request(1'b1, pick_percent(), 1'($urandom));
    repeat (hold_run) send_request(1'b0, PctW'($urandom), 1'b1);
    repeat (coast) send_request(1'b0, PctW'($urandom), 1'($urandom));
  endtask

  task automatic noise_request();
    send_request(1'($urandom_range(0, 3) == 0), PctW'($urandom), 1'($urandom));
  endtask

  initial begin
    logic [DebW-1:0]     deb;
    logic [TimeoutW-1:0] fault_limit;
    int                  phase_start;
    bit                  paused;

    // every input known from time zero
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_MAX_TRAVEL;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.req_type = 1'b0;
    in_ch.position_percent = '0;
    in_ch.sensor_level = 1'b0;
    out_ch.ready = 1'b0;
    gap_pct = 0;
    stall_pct = 0;
    n_requests = 0;
    n_commands = 0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset register values: ticks while idle, clamped command,
    // a few homing ticks that cannot reach the 200-tick hold
    send_request(1'b0, 7'd127, 1'b0);
    send_request(1'b1, 7'd101, 1'b1);
    send_request(1'b0, 7'd0, 1'b1);
    send_request(1'b0, 7'd127, 1'b0);
    wait_drained();

    // directed, tiny travel and shortest nonzero debounce
    program_regs(16'd3, 16'hFFFF, 8'd1);
    send_request(1'b0, 7'd127, 1'b0);
    send_request(1'b0, 7'd0, 1'b1);
    // zero target: homing ends straight in idle, with one bounce first
    send_request(1'b1, 7'd0, 1'b1);
    send_request(1'b0, 7'd0, 1'b1);
    send_request(1'b0, 7'd0, 1'b0);
    send_request(1'b0, 7'd0, 1'b1);
    send_request(1'b0, 7'd0, 1'b1);
    // above full scale clamps to 100, full left travel of three ticks runs out
    send_request(1'b1, 7'd127, 1'b0);
    send_request(1'b0, 7'd5, 1'b1);
    send_request(1'b0, 7'd5, 1'b1);
    send_request(1'b0, 7'd5, 1'b0);
    send_request(1'b0, 7'd5, 1'b1);
    send_request(1'b0, 7'd5, 1'b0);
    // command while moving left, then command while homing
    send_request(1'b1, 7'd100, 1'b0);
    send_request(1'b0, 7'd64, 1'b1);
    send_request(1'b0, 7'd64, 1'b1);
    send_request(1'b1, 7'd67, 1'b1);
    send_request(1'b1, 7'd1, 1'b0);
    send_request(1'b0, 7'd0, 1'b1);
    send_request(1'b0, 7'd0, 1'b1);
    send_request(1'b1, 7'd50, 1'b1);

    // random phases, each with its own register setting and idling pattern
    for (int ph = 0; ph < 8; ph++) begin
      wait_drained();
      case (ph)
        0: deb = 8'd1;
        1: deb = DebW'($urandom_range(2, 6));
        2: deb = DebW'($urandom_range(1, 4));
        3: deb = HOLD_MAX;
        4: deb = RST_DEBOUNCE;
        5: deb = DebW'($urandom_range(1, 10));
        6: deb = 8'd1;
        default: deb = DebW'($urandom_range(1, 8));
      endcase
      // homing timeouts stay far above anything this run can count up to,
      // so the sticky fault only comes in the last phase
      case (ph)
        0: program_regs(TravelW'($urandom_range(1, 60)), 16'hFFFF, deb);
        1: program_regs('0, TimeoutW'($urandom_range(4096, 65535)), deb);
        2: program_regs(16'hFFFF, RST_HOME_TIMEOUT, deb);
        3: program_regs(TravelW'($urandom_range(0, 300)),
                        TimeoutW'($urandom_range(4096, 65535)), deb);
        4: program_regs(RST_MAX_TRAVEL, RST_HOME_TIMEOUT, deb);
        5: program_regs(TravelW'($urandom_range(1, 500)),
                        TimeoutW'($urandom_range(4096, 65535)), deb);
        6: program_regs(TravelW'($urandom_range(0, 40)), 16'hFFFF, deb);
        default: program_regs(TravelW'($urandom), TimeoutW'($urandom_range(4096, 65535)), deb);
      endcase
      case (ph % 4)
        0: begin
          gap_pct = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct = 61;
          stall_pct = 0;
        end
        2: begin
          gap_pct = 0;
          stall_pct = 61;
        end
        default: begin
          gap_pct = 13;
          stall_pct = 13;
        end
      endcase
      phase_start = n_requests;
      paused = 1'b0;
      while (n_requests - phase_start < 170) begin
        // halfway through, let the pipe run completely dry once
        if (!paused && n_requests - phase_start >= 85) begin
          wait_drained();
          paused = 1'b1;
        end
        if ($urandom_range(0, 99) < 80) homing_run(32'(deb));
        else noise_request();
      end
    end

    // last phase: a timeout within reach of the current homing count,
    // the shortest nonzero one when nothing has been counted, then prove it sticks
    wait_drained();
    gap_pct = 13;
    stall_pct = 13;
    fault_limit = (seq_home_ticks == '0) ? 16'd1
                                         : seq_home_ticks + TimeoutW'($urandom_range(1, 40));
    program_regs(TravelW'($urandom_range(0, 200)), fault_limit,
                 DebW'($urandom_range(1, 4)));
    send_request(1'b1, pick_percent(), 1'b0);
    repeat (60) send_request(1'b0, PctW'($urandom), 1'b0);
    repeat (20) noise_request();

    wait_drained();
    repeat (5) @(posedge clk);

    $display("%0d requests sent, %0d of them position commands; %0d results compared",
             n_requests, n_commands, results_checked);
    $display("travel and debounce swept to both ends, homing ended in a sticky fault; mode %0d",
             seq_mode);
    if (fail_count == 0 && outstanding == 0) begin
      $display("homing_positioner_with_debounce_unit test passed");
    end else begin
      $display("homing_positioner_with_debounce_unit test failed");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #2ms;
    $display("timeout: results stopped arriving");
    $display("homing_positioner_with_debounce_unit test failed");
    $finish;
  end

endmodule

### sim.f
src/hps_pkg.sv
src/hps_if.sv
src/hps_step.sv
src/homing_positioner_with_debounce_unit.sv
tb/sv/homing_sequence_monitor.sv
tb/sv/homing_positioner_with_debounce_unit_test.sv
